### sv/assert_macros.svh
// assertion helpers for the lzw checker
// each macro expects clk and rst in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define LZW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzw check failed: same-cycle implication");

// next-cycle implication, idle during reset
`define LZW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzw check failed: next-cycle implication");

`endif

### sv/lzw_pkg.sv
package lzw_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int CODE_CAP     = 4096;
  localparam int CODE_LIMIT   = (DICT_ENTRIES < CODE_CAP) ? DICT_ENTRIES : CODE_CAP;
  localparam int FIRST_CODE   = 256;

  localparam int BYTE_W = 8;
  localparam int CODE_W = 12;
  localparam int FREE_W = CODE_W + 1;
  localparam int KEY_W  = CODE_W + BYTE_W;

  // hash table holds at least twice as many slots as codes, so probing always ends
  localparam int HT_AW    = $clog2(CODE_LIMIT) + 1;
  localparam int HT_DEPTH = 1 << HT_AW;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] sym;
    logic [CODE_W-1:0] code;
  } ht_entry_t;

  typedef struct packed {
    logic load;       // latch the incoming byte and end flag
    logic take_first; // first byte of a stream becomes the prefix
    logic rd_first;   // read the home slot of (prefix, byte)
    logic rd_next;    // read the following slot
    logic hit;        // prefix takes the matched code
    logic miss;       // emit prefix, insert pair while codes remain, restart from byte
    logic final_code; // emit the last prefix of the stream
    logic clr;        // clear one slot of the table
  } lzw_cmd_t;

  typedef struct packed {
    logic held;
    logic in_end;
    logic cur_end;
    logic ent_valid;
    logic ent_match;
    logic out_free;
    logic clr_last;
  } lzw_sts_t;

  function automatic logic [HT_AW-1:0] pair_hash(input logic [CODE_W-1:0] prefix,
                                                 input logic [BYTE_W-1:0] sym);
    logic [KEY_W-1:0] key;
    key = {prefix, sym};
    return key[HT_AW-1:0] ^ HT_AW'(key >> (KEY_W - HT_AW));
  endfunction

endpackage

### sv/lzw_in_if.sv
interface lzw_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzw_pkg::BYTE_W-1:0] byte_in;
  logic                      end_of_input;

  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

### sv/lzw_out_if.sv
interface lzw_out_if;
  logic                      valid;
  logic                      ready;
  logic [lzw_pkg::CODE_W-1:0] code_out;
  logic                      run_last;
  logic                      stream_done;

  modport source (output valid, output code_out, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input code_out, input run_last, input stream_done,
                output ready);
endinterface

### sv/lzw_dpath.sv
module lzw_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lzw_pkg::BYTE_W-1:0] byte_in,
  input  logic                       end_of_input,
  input  lzw_pkg::lzw_cmd_t          cmd,
  output lzw_pkg::lzw_sts_t          sts,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lzw_pkg::CODE_W-1:0] code_out,
  output logic                       run_last,
  output logic                       stream_done
);

  logic [lzw_pkg::CODE_W-1:0] prefix_code;
  logic                       prefix_held;
  logic [lzw_pkg::FREE_W-1:0] next_free_code;
  logic [lzw_pkg::BYTE_W-1:0] cur_byte;
  logic                       cur_end;
  logic [lzw_pkg::HT_AW-1:0]  probe;
  logic [lzw_pkg::HT_AW-1:0]  clr_addr;

  lzw_pkg::ht_entry_t mem [lzw_pkg::HT_DEPTH];
  lzw_pkg::ht_entry_t rd_data;
  lzw_pkg::ht_entry_t wr_data;

  logic [lzw_pkg::HT_AW-1:0] hash_addr;
  logic [lzw_pkg::HT_AW-1:0] rd_addr;
  logic [lzw_pkg::HT_AW-1:0] wr_addr;
  logic                      rd_en;
  logic                      wr_en;
  logic                      room;
  logic                      push;

  assign hash_addr = lzw_pkg::pair_hash(prefix_code, byte_in);
  assign rd_addr   = cmd.rd_first ? hash_addr : probe + 1'b1;
  assign rd_en     = cmd.rd_first | cmd.rd_next;
  assign room      = next_free_code < lzw_pkg::FREE_W'(lzw_pkg::CODE_LIMIT);
  assign wr_en     = cmd.clr | (cmd.miss & room);
  assign wr_addr   = cmd.clr ? clr_addr : probe;
  assign push      = cmd.miss | cmd.final_code;

  always_comb begin
    wr_data = '0;
    if (!cmd.clr) begin
      wr_data.valid  = 1'b1;
      wr_data.prefix = prefix_code;
      wr_data.sym    = cur_byte;
      wr_data.code   = next_free_code[lzw_pkg::CODE_W-1:0];
    end
  end

  // pair hash table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_code    <= '0;
      prefix_held    <= 1'b0;
      next_free_code <= lzw_pkg::FREE_W'(lzw_pkg::FIRST_CODE);
      clr_addr       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.take_first) begin
        prefix_code <= lzw_pkg::CODE_W'(byte_in);
        prefix_held <= 1'b1;
      end
      if (cmd.hit) begin
        prefix_code <= rd_data.code;
      end
      if (cmd.miss) begin
        prefix_code <= lzw_pkg::CODE_W'(cur_byte);
        if (room) begin
          next_free_code <= next_free_code + 1'b1;
        end
      end
      if (cmd.final_code) begin
        prefix_held <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= byte_in;
      cur_end  <= end_of_input;
    end
    if (rd_en) begin
      probe <= rd_addr;
    end
    if (push) begin
      code_out    <= prefix_code;
      run_last    <= cmd.final_code | ~cur_end;
      stream_done <= cmd.final_code;
    end
  end

  always_comb begin
    sts.held      = prefix_held;
    sts.in_end    = end_of_input;
    sts.cur_end   = cur_end;
    sts.ent_valid = rd_data.valid;
    sts.ent_match = rd_data.valid && (rd_data.prefix == prefix_code) &&
                    (rd_data.sym == cur_byte);
    sts.out_free  = ~out_valid | out_ready;
    sts.clr_last  = &clr_addr;
  end

endmodule

### sv/lzw_ctrl.sv
module lzw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzw_pkg::lzw_sts_t sts,
  output lzw_pkg::lzw_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_MISS  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.held) begin
            cmd.rd_first = 1'b1;
            state_next   = S_CMP;
          end else begin
            cmd.take_first = 1'b1;
            if (sts.in_end) begin
              state_next = S_FINAL;
            end
          end
        end
      end
      S_CMP: begin
        if (sts.ent_match) begin
          cmd.hit    = 1'b1;
          state_next = sts.cur_end ? S_FINAL : S_IDLE;
        end else if (sts.ent_valid) begin
          cmd.rd_next = 1'b1;
        end else if (sts.out_free) begin
          cmd.miss   = 1'b1;
          state_next = sts.cur_end ? S_FINAL : S_IDLE;
        end else begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        if (sts.out_free) begin
          cmd.miss   = 1'b1;
          state_next = sts.cur_end ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.final_code = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/lzw_byte_encoder.sv
// 12-bit lzw byte compressor. One byte per transfer on byte_ch, with end_of_input
// marking the last byte of a stream; codes leave on code_ch, at most two per byte.
// The dictionary of (prefix, byte) pairs lives in a hash table of HT_DEPTH slots
// (8192 x 33 bits at the default size) with linear probing; it is never more than
// about half full, so a lookup normally takes one read. After reset the block
// clears the table one slot a cycle, all HT_DEPTH slots (8192 by default), with
// byte_ch.ready low. The first byte of a stream becomes the prefix; any other byte
// reads its home slot, then each following slot while it finds other pairs, to a
// hit or a miss; a closing byte then emits the final code, and only then is a new
// byte taken, given the single table read port and one result register. A miss
// or the final code also waits while the result register still holds a code that
// has not been taken. The dictionary stops growing once all codes are assigned
// and is cleared only by reset; a new stream keeps the dictionary as it stands.
module lzw_byte_encoder (
  input logic       clk,
  input logic       rst,
  lzw_in_if.sink    byte_ch,
  lzw_out_if.source code_ch
);

  // command and status between the sequencer and the datapath
  lzw_pkg::lzw_cmd_t cmd;
  lzw_pkg::lzw_sts_t sts;

  // sequencer: clearing pass, lookup and probing, emitting codes
  lzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_ch.valid),
    .in_ready (byte_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // prefix state, hash table and the result register
  lzw_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_ch.byte_in),
    .end_of_input (byte_ch.end_of_input),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (code_ch.valid),
    .out_ready    (code_ch.ready),
    .code_out     (code_ch.code_out),
    .run_last     (code_ch.run_last),
    .stream_done  (code_ch.stream_done)
  );

endmodule

### sv/lzw_chk.sv
`include "assert_macros.svh"

module lzw_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       end_of_input,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lzw_pkg::CODE_W-1:0] code_out,
  input logic                       run_last,
  input logic                       stream_done
);

  // code and flags as one word, for the hold check
  logic [lzw_pkg::CODE_W+1:0] out_word;

  assign out_word = {code_out, run_last, stream_done};

  // a stalled result holds its code and flags
  `LZW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // the final code of a stream is always the last one of its byte
  `LZW_ASSERT_IMPL(a_done_last, out_valid && stream_done, run_last)

  // a closing byte still owes its final code, so no byte is taken next cycle
  `LZW_ASSERT_NEXT(a_end_busy, in_valid && in_ready && end_of_input, !in_ready)

  // table clearing keeps the input closed right after reset
  `LZW_ASSERT_IMPL(a_clear_busy, $fell(rst), !in_ready)

endmodule

bind lzw_byte_encoder lzw_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (byte_ch.valid),
  .in_ready     (byte_ch.ready),
  .end_of_input (byte_ch.end_of_input),
  .out_valid    (code_ch.valid),
  .out_ready    (code_ch.ready),
  .code_out     (code_ch.code_out),
  .run_last     (code_ch.run_last),
  .stream_done  (code_ch.stream_done)
);

### bench/lzw_byte_encoder_test.sv
`timescale 1ns / 1ps

module lzw_byte_encoder_test;

  // one emitted code as it leaves the block
  typedef struct packed {
    logic [lzw_pkg::CODE_W-1:0] code;
    logic                       run_last;
    logic                       stream_done;
  } code_word_t;

  // tracks the compressor state and the codes it still owes
  class lzw_code_ledger;
    logic [lzw_pkg::CODE_W-1:0] prefix;
    bit                         held;
    int unsigned                next_free;
    int unsigned                pair_code [bit [lzw_pkg::KEY_W-1:0]];
    code_word_t                 codes_due [$];
    int                         mismatches;
    int                         codes_checked;
    int                         streams_done;
    int                         pair_hits;

    function new();
      prefix    = '0;
      held      = 1'b0;
      next_free = lzw_pkg::FIRST_CODE;
    endfunction

    // a byte went in: work out which codes it releases
    function void note_byte(logic [lzw_pkg::BYTE_W-1:0] data, logic last_byte);
      bit [lzw_pkg::KEY_W-1:0] key;
      if (!held) begin
        prefix = lzw_pkg::CODE_W'(data);
        held   = 1'b1;
      end else begin
        key = {prefix, data};
        if (pair_code.exists(key)) begin
          prefix = lzw_pkg::CODE_W'(pair_code[key]);
          pair_hits++;
        end else begin
          codes_due.push_back('{code: prefix, run_last: !last_byte, stream_done: 1'b0});
          if (next_free < lzw_pkg::CODE_LIMIT) begin
            pair_code[key] = next_free;
            next_free++;
          end
          prefix = lzw_pkg::CODE_W'(data);
        end
      end
      if (last_byte) begin
        codes_due.push_back('{code: prefix, run_last: 1'b1, stream_done: 1'b1});
        held = 1'b0;
        streams_done++;
      end
    endfunction

    // a code came out: compare it with the oldest one owed
    function void check_code(logic [lzw_pkg::CODE_W-1:0] code, logic run_last,
                             logic stream_done);
      code_word_t want;
      if (codes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected code %0d run_last %0b stream_done %0b",
                   code, run_last, stream_done);
        return;
      end
      want = codes_due.pop_front();
      codes_checked++;
      if (code !== want.code || run_last !== want.run_last ||
          stream_done !== want.stream_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("code mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b (code/last/done)",
                   want.code, want.run_last, want.stream_done,
                   code, run_last, stream_done);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  lzw_in_if  byte_ch ();
  lzw_out_if code_ch ();

  lzw_byte_encoder DUT (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .code_ch (code_ch)
  );

  lzw_code_ledger ledger = new();

  // idling controls shared between the stimulus and the code receiver
  bit in_gaps_on       = 1'b1;
  bit out_gaps_on      = 1'b1;
  int code_hold_cycles = 0;
  int bytes_sent       = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offer one byte, optionally after a random gap, and wait for its transfer
  task automatic send_byte(input logic [lzw_pkg::BYTE_W-1:0] data, input logic last_byte);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid        <= 1'b1;
    byte_ch.byte_in      <= data;
    byte_ch.end_of_input <= last_byte;
    do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
    ledger.note_byte(data, last_byte);
    bytes_sent++;
  endtask

  // one whole stream; a narrow alphabet gives long dictionary chains
  task automatic send_random_stream(input int len, input int alphabet);
    logic [lzw_pkg::BYTE_W-1:0] base;
    logic [lzw_pkg::BYTE_W-1:0] data;
    base = lzw_pkg::BYTE_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      if (alphabet >= 256)
        data = lzw_pkg::BYTE_W'($urandom_range(0, 255));
      else
        data = base + lzw_pkg::BYTE_W'($urandom_range(0, alphabet - 1));
      send_byte(data, i == len - 1);
    end
  endtask

  // pause the byte side until every owed code has come out
  task automatic wait_codes_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.codes_due.size() != 0);
  endtask

  // mostly short streams, now and then a long one
  function automatic int pick_stream_len();
    if ($urandom_range(0, 9) < 7)
      return $urandom_range(1, 24);
    return $urandom_range(25, 150);
  endfunction

  function automatic int pick_alphabet();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return 2;
      2: return 3;
      3: return 4;
      4: return 16;
      default: return 256;
    endcase
  endfunction

  // code receiver: random stalls, plus a long hold when asked
  initial begin
    int gap;
    code_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (code_hold_cycles > 0) begin
        gap = code_hold_cycles;
        code_hold_cycles = 0;
      end else begin
        gap = out_gaps_on ? $urandom_range(0, 17) : 0;
      end
      if (gap > 0) begin
        code_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      code_ch.ready <= 1'b1;
      do @(posedge clk); while (!(code_ch.valid && code_ch.ready));
      ledger.check_code(code_ch.code_out, code_ch.run_last, code_ch.stream_done);
    end
  end

  // stimulus and end of run
  initial begin
    int stream_count;
    byte_ch.valid        = 1'b0;
    byte_ch.byte_in      = '0;
    byte_ch.end_of_input = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // single-byte streams at both ends of the byte range
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // alternating pair: hits grow the prefix into dictionary codes
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b1);
    // new stream reuses the dictionary; ends on a hit, so only the final code
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    // run of one byte, ends on a miss so two codes come out of the last byte
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    // checkerboard bit patterns and the range ends mixed in one stream
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);

    // long receiver hold while bytes keep coming, so the input backs up
    in_gaps_on       = 1'b0;
    code_hold_cycles = 400;
    send_random_stream(150, 256);
    // byte side waits until the block has handed over everything
    wait_codes_drained();

    // random streams with random idling on both sides
    stream_count = 0;
    while (bytes_sent < 1000) begin
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      send_random_stream(pick_stream_len(), pick_alphabet());
      stream_count++;
      if (stream_count % 40 == 0)
        wait_codes_drained();
    end

    // back-to-back stretch with the receiver always ready, then random again
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    send_random_stream(150, 256);
    while (bytes_sent < 1300) begin
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      send_random_stream(pick_stream_len(), pick_alphabet());
    end

    out_gaps_on = 1'b1;
    wait_codes_drained();
    repeat (40) @(posedge clk);

    $display("sent %0d bytes in %0d streams, %0d codes checked, %0d pair hits",
             bytes_sent, ledger.streams_done, ledger.codes_checked, ledger.pair_hits);
    $display("dictionary grew to code %0d, %0d mismatches",
             ledger.next_free, ledger.mismatches);
    if (ledger.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### lzw_byte_encoder.f
+incdir+sv
sv/lzw_pkg.sv
sv/lzw_in_if.sv
sv/lzw_out_if.sv
sv/lzw_dpath.sv
sv/lzw_ctrl.sv
sv/lzw_byte_encoder.sv
sv/lzw_chk.sv
bench/lzw_byte_encoder_test.sv
